@@ rtl/paired_hit_gap_histogram_assert.svh @@
// Assertion macros for the checker of the gap histogram block.
`ifndef PAIRED_HIT_GAP_HISTOGRAM_ASSERT_SVH
`define PAIRED_HIT_GAP_HISTOGRAM_ASSERT_SVH

// Check a property on every rising edge, reset included.
`define PHGH_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on rising edges outside of reset.
`define PHGH_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

@@ rtl/phgh_pkg.sv @@
`default_nettype none

package phgh_pkg;

    // Default sizes of the histogram and of the forward delay line
    localparam int NUM_BINS_DEF  = 4096;
    localparam int MAX_SHIFT_DEF = 65536;

    // Fixed field widths
    localparam int SHIFT_W    = 16;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 32;
    localparam int POS_W      = 17;
    localparam int ADDR_W_MAX = 16;

    // Depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // Request codes on the input channel
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Operation codes carried through the queue
    localparam logic [1:0] OP_HIT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]            op;
        logic                  oor;
        logic [ADDR_W_MAX-1:0] addr;
    } q_entry_t;

    // Saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/paired_hit_gap_histogram.sv @@
// A read word passes classify stage, queue, execute stage and output register to m_valid;
// samples give no word. Throughput: one word per cycle unless a clear sweep or a held result
// stalls it; the histogram update forwards its last write to keep pace. A clear word holds
// the histogram side while it sweeps the bin memory. Reset: synchronous, active low; then a
// clearing pass of the bins runs with s_ready low. The forward delay line is not cleared.
`default_nettype none

module paired_hit_gap_histogram
    import phgh_pkg::*;
#(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [SHIFT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_fwd_read,
    input  logic               s_rev_read,
    input  logic               s_chrom_start,
    input  logic [IDX_W-1:0]   s_bin_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CNT_W-1:0]   m_bin_count,
    output logic [CNT_W-1:0]   m_total_hits
);

    logic     push_valid, push_ready, pop_valid, pop_ready, init_busy;
    q_entry_t push_entry, pop_entry;

    // Accept, delay forward reads and detect pair hits
    phgh_front #(
        .NUM_BINS  (NUM_BINS),
        .MAX_SHIFT (MAX_SHIFT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_fwd_read    (s_fwd_read),
        .s_rev_read    (s_rev_read),
        .s_chrom_start (s_chrom_start),
        .s_bin_index   (s_bin_index),
        .hold_in       (init_busy),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry)
    );

    // Decouple front and back
    phgh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Update, read and clear the histogram
    phgh_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .init_busy    (init_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_count  (m_bin_count),
        .m_total_hits (m_total_hits)
    );

endmodule

`default_nettype wire

@@ rtl/phgh_front.sv @@
`default_nettype none

module phgh_front
    import phgh_pkg::*;
#(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int MAX_SHIFT = MAX_SHIFT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [SHIFT_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic               s_fwd_read,
    input  logic               s_rev_read,
    input  logic               s_chrom_start,
    input  logic [IDX_W-1:0]   s_bin_index,
    input  logic               hold_in,
    output logic               push_valid,
    input  logic               push_ready,
    output q_entry_t           push_entry
);

    localparam int BW = $clog2(NUM_BINS);
    localparam int AW = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
    localparam int DW = ((AW > SHIFT_W) ? AW : SHIFT_W) + 1;
    localparam int OW = ADDR_W_MAX + 1;

    logic [SHIFT_W-1:0] shift_len_reg;
    logic [POS_W-1:0]   pos_reg, pos_cur, pos_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_cur, wr_ptr_next, rd_addr;
    logic [DW-1:0]      wr_x, shift_x, rd_x;
    logic               s_fire, is_sample, eligible, zero_shift, idx_oor;

    logic               dly_mem [MAX_SHIFT];
    logic               dly_rd_q;

    logic               st1_valid_reg;
    logic [1:0]         st1_req_reg;
    logic               st1_elig_reg, st1_zero_reg, st1_fwd_reg, st1_rev_reg;
    logic               st1_start_reg, st1_oor_reg;
    logic [IDX_W-1:0]   st1_idx_reg;
    logic [BW-1:0]      gap_reg, gap_cur, gap_next;
    logic               delayed, hit, push_want, st1_go;

    // Hold the shift length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_len_reg <= '0;
        end else if (cfg_wr_en) begin
            shift_len_reg <= cfg_wr_data;
        end
    end

    // Classify the word and work out position, eligibility and delay taps
    always_comb begin
        s_fire      = s_valid && s_ready;
        is_sample   = (s_req_type == REQ_SAMPLE);
        pos_cur     = s_chrom_start ? '0 : pos_reg;
        wr_ptr_cur  = s_chrom_start ? '0 : wr_ptr_reg;
        pos_next    = (&pos_cur) ? pos_cur : pos_cur + 1'b1;
        wr_ptr_next = (wr_ptr_cur == AW'(MAX_SHIFT - 1)) ? '0 : wr_ptr_cur + 1'b1;
        shift_x     = DW'(shift_len_reg);
        wr_x        = DW'(wr_ptr_cur);
        eligible    = (shift_x < DW'(MAX_SHIFT)) && (pos_cur >= POS_W'(shift_len_reg));
        zero_shift  = (shift_len_reg == '0);
        rd_x        = (wr_x >= shift_x) ? wr_x - shift_x : wr_x + DW'(MAX_SHIFT) - shift_x;
        rd_addr     = rd_x[AW-1:0];
        idx_oor     = (OW'(s_bin_index) >= OW'(NUM_BINS));
    end

    // Advance position counter and delay line write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
        end else if (s_fire && is_sample) begin
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Forward read delay line
    always_ff @(posedge aclk) begin
        if (s_fire && is_sample) begin
            dly_mem[wr_ptr_cur] <= s_fwd_read;
            dly_rd_q            <= dly_mem[rd_addr];
        end
    end

    // Decide the pair hit and the queue operation
    always_comb begin
        delayed    = st1_zero_reg ? st1_fwd_reg : dly_rd_q;
        hit        = st1_elig_reg && delayed && st1_rev_reg;
        gap_cur    = st1_start_reg ? '0 : gap_reg;
        gap_next   = gap_cur;
        push_want  = 1'b0;
        push_entry = '{op: OP_HIT, oor: 1'b0, addr: ADDR_W_MAX'(gap_cur)};
        case (st1_req_reg)
            REQ_SAMPLE: begin
                push_want = hit;
                if (st1_elig_reg) begin
                    if (hit) begin
                        gap_next = BW'(1);
                    end else if (gap_cur != BW'(NUM_BINS - 1)) begin
                        gap_next = gap_cur + 1'b1;
                    end
                end
            end
            REQ_READ: begin
                push_want  = 1'b1;
                push_entry = '{op: OP_READ, oor: st1_oor_reg,
                               addr: ADDR_W_MAX'(st1_idx_reg)};
            end
            REQ_CLEAR: begin
                push_want  = 1'b1;
                push_entry = '{op: OP_CLEAR, oor: 1'b0, addr: '0};
            end
            default: begin
                push_want = 1'b0;
            end
        endcase
        push_valid = st1_valid_reg && push_want;
        st1_go     = st1_valid_reg && (!push_want || push_ready);
        s_ready    = (!st1_valid_reg || st1_go) && !hold_in;
    end

    // Load and drain the classify stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            gap_reg       <= '0;
        end else begin
            if (s_fire) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_go) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_go) begin
                gap_reg <= gap_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_req_reg   <= s_req_type;
            st1_elig_reg  <= eligible;
            st1_zero_reg  <= zero_shift;
            st1_fwd_reg   <= s_fwd_read;
            st1_rev_reg   <= s_rev_read;
            st1_start_reg <= s_chrom_start && is_sample;
            st1_oor_reg   <= idx_oor;
            st1_idx_reg   <= s_bin_index;
        end
    end

endmodule

`default_nettype wire

@@ rtl/phgh_queue.sv @@
`default_nettype none

module phgh_queue
    import phgh_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    q_entry_t      q_mem [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push_fire, pop_fire;

    always_comb begin
        push_ready = (cnt_reg != CW'(Q_DEPTH));
        pop_valid  = (cnt_reg != '0);
        pop_entry  = q_mem[rd_ptr_reg];
        push_fire  = push_valid && push_ready;
        pop_fire   = pop_valid && pop_ready;
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/phgh_back.sv @@
`default_nettype none

module phgh_back
    import phgh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  q_entry_t         pop_entry,
    output logic             init_busy,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CNT_W-1:0] m_bin_count,
    output logic [CNT_W-1:0] m_total_hits
);

    localparam int BW = $clog2(NUM_BINS);

    logic [CNT_W-1:0] hist_mem [NUM_BINS];
    logic [CNT_W-1:0] hist_rd_q;

    logic             stb_valid_reg, stb_oor_reg;
    logic [1:0]       stb_op_reg;
    logic [BW-1:0]    stb_addr_reg;
    logic             fwd_valid_reg;
    logic [BW-1:0]    fwd_addr_reg;
    logic [CNT_W-1:0] fwd_data_reg;
    logic [CNT_W-1:0] hit_total_reg;
    logic             clr_busy_reg, init_reg;
    logic [BW-1:0]    clr_addr_reg;
    logic             out_valid_reg;
    logic [CNT_W-1:0] out_bin_reg, out_total_reg;

    logic             out_free, stb_is_hit, stb_is_read, stb_done;
    logic             pop_fire, pop_clear, wr_en;
    logic [BW-1:0]    pop_addr, wr_addr;
    logic [CNT_W-1:0] bin_val, new_val, wr_data;

    // Pick the freshest bin value and steer the single write port
    always_comb begin
        bin_val     = (fwd_valid_reg && (fwd_addr_reg == stb_addr_reg)) ?
                      fwd_data_reg : hist_rd_q;
        new_val     = sat_inc(bin_val);
        out_free    = !out_valid_reg || m_ready;
        stb_is_hit  = stb_valid_reg && (stb_op_reg == OP_HIT);
        stb_is_read = stb_valid_reg && (stb_op_reg == OP_READ);
        stb_done    = !stb_is_read || out_free;
        pop_ready   = !clr_busy_reg && stb_done;
        pop_fire    = pop_valid && pop_ready;
        pop_clear   = pop_fire && (pop_entry.op == OP_CLEAR);
        pop_addr    = pop_entry.addr[BW-1:0];
        wr_en       = stb_is_hit || clr_busy_reg;
        wr_addr     = clr_busy_reg ? clr_addr_reg : stb_addr_reg;
        wr_data     = clr_busy_reg ? '0 : new_val;
        init_busy   = init_reg;
    end

    // Histogram memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (pop_fire) begin
            hist_rd_q <= hist_mem[pop_addr];
        end
    end

    // Execute stage, total count and clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stb_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            hit_total_reg <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            init_reg      <= 1'b1;
        end else begin
            if (pop_fire && !pop_clear) begin
                stb_valid_reg <= 1'b1;
            end else if (stb_done) begin
                stb_valid_reg <= 1'b0;
            end

            if (clr_busy_reg) begin
                fwd_valid_reg <= 1'b0;
            end else if (stb_is_hit) begin
                fwd_valid_reg <= 1'b1;
            end

            if (pop_clear) begin
                hit_total_reg <= '0;
            end else if (stb_is_hit) begin
                hit_total_reg <= sat_inc(hit_total_reg);
            end

            if (pop_clear) begin
                clr_busy_reg <= 1'b1;
                clr_addr_reg <= '0;
            end else if (clr_busy_reg) begin
                if (clr_addr_reg == BW'(NUM_BINS - 1)) begin
                    clr_busy_reg <= 1'b0;
                    init_reg     <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            stb_op_reg   <= pop_entry.op;
            stb_oor_reg  <= pop_entry.oor;
            stb_addr_reg <= pop_addr;
        end
        if (stb_is_hit && !clr_busy_reg) begin
            fwd_addr_reg <= stb_addr_reg;
            fwd_data_reg <= new_val;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stb_is_read && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stb_is_read && out_free) begin
            out_bin_reg   <= stb_oor_reg ? '0 : bin_val;
            out_total_reg <= hit_total_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_bin_count  = out_bin_reg;
    assign m_total_hits = out_total_reg;

endmodule

`default_nettype wire

@@ rtl/phgh_checker.sv @@
`default_nettype none
`include "paired_hit_gap_histogram_assert.svh"

module phgh_checker
    import phgh_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CNT_W-1:0] m_bin_count,
    input logic [CNT_W-1:0] m_total_hits
);

    // Reset empties the output and starts the clearing pass
    `PHGH_ASSERT(a_reset_quiet, aclk, !aresetn |=> !s_ready && !m_valid, "busy after reset")

    // The clearing pass keeps s_ready low past reset release
    `PHGH_ASSERT(a_init_hold, aclk, !aresetn ##1 aresetn |=> !s_ready, "ready during clear pass")

    // A single bin never exceeds the total
    `PHGH_ASSERT_RST(a_bin_le_total, aclk, aresetn, m_valid |-> m_total_hits >= m_bin_count, "bin above total")

    // A stalled word holds
    `PHGH_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_bin_count) && $stable(m_total_hits), "stalled word changed")

endmodule

bind paired_hit_gap_histogram phgh_checker u_phgh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_bin_count  (m_bin_count),
    .m_total_hits (m_total_hits)
);

`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

module tb_top;
    import phgh_pkg::*;

    // Request code that the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int BIN_LAST = NUM_BINS_DEF - 1;
    localparam logic [POS_W-1:0] POS_LAST = {POS_W{1'b1}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [1:0]       req;
        logic             fwd;
        logic             rev;
        logic             start;
        logic [IDX_W-1:0] idx;
    } hist_word_t;

    typedef struct {
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] total_hits;
    } bin_read_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SHIFT_W-1:0] cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_req_type = REQ_SAMPLE;
    logic               s_fwd_read = 1'b0;
    logic               s_rev_read = 1'b0;
    logic               s_chrom_start = 1'b0;
    logic [IDX_W-1:0]   s_bin_index = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CNT_W-1:0]   m_bin_count;
    logic [CNT_W-1:0]   m_total_hits;

    paired_hit_gap_histogram DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_fwd_read    (s_fwd_read),
        .s_rev_read    (s_rev_read),
        .s_chrom_start (s_chrom_start),
        .s_bin_index   (s_bin_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_bin_count   (m_bin_count),
        .m_total_hits  (m_total_hits)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    hist_word_t pending_words[$];
    bin_read_t  expected_reads[$];
    int         errors = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    bit         in_taken = 1'b0;

    // Shadow copy of the block state
    bit               fwd_line [0:MAX_SHIFT_DEF-1];
    logic [CNT_W-1:0] gap_hist [0:NUM_BINS_DEF-1];
    logic [IDX_W-1:0] gap_cnt = '0;
    logic [POS_W-1:0] pos_cnt = '0;
    logic [CNT_W-1:0] hit_cnt = '0;
    logic [15:0]      wr_ptr = '0;
    logic [SHIFT_W-1:0] shift_q = '0;

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Advance the shadow state by one genome position
    task automatic track_position(input logic fwd, input logic rev, input logic start);
        logic        eligible;
        logic        delayed;
        logic [15:0] rd_ptr;
        if (start) begin
            pos_cnt = '0;
            gap_cnt = '0;
            wr_ptr  = '0;
        end
        eligible = (pos_cnt >= {1'b0, shift_q});
        delayed  = 1'b0;
        rd_ptr   = wr_ptr - shift_q;
        if (eligible) begin
            delayed = (shift_q == '0) ? fwd : fwd_line[rd_ptr];
        end
        fwd_line[wr_ptr] = fwd;
        wr_ptr = wr_ptr + 16'd1;
        if (eligible) begin
            if (delayed && rev) begin
                gap_hist[gap_cnt] = bump_count(gap_hist[gap_cnt]);
                hit_cnt = bump_count(hit_cnt);
                gap_cnt = 12'd1;
            end else if (gap_cnt != BIN_LAST[IDX_W-1:0]) begin
                gap_cnt = gap_cnt + 1'b1;
            end
        end
        if (pos_cnt != POS_LAST) pos_cnt = pos_cnt + 1'b1;
    endtask

    // Apply one accepted word to the shadow state
    task automatic predict_word(input hist_word_t w);
        bin_read_t r;
        case (w.req)
            REQ_SAMPLE: begin
                track_position(w.fwd, w.rev, w.start);
            end
            REQ_READ: begin
                r.bin_count  = gap_hist[w.idx];
                r.total_hits = hit_cnt;
                expected_reads.push_back(r);
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NUM_BINS_DEF; i++) gap_hist[i] = '0;
                hit_cnt = '0;
            end
            default: ;
        endcase
    endtask

    // Catch accepted input words
    always @(posedge aclk) begin
        hist_word_t w;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            w.req   = s_req_type;
            w.fwd   = s_fwd_read;
            w.rev   = s_rev_read;
            w.start = s_chrom_start;
            w.idx   = s_bin_index;
            predict_word(w);
        end
    end

    // Drive the next word, or idle; hold a word until it is taken
    always @(negedge aclk) begin
        hist_word_t w;
        bit         go;
        if (aresetn && (!s_valid || in_taken)) begin
            go = (pending_words.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
            if (go) begin
                w = pending_words.pop_front();
                s_req_type    <= w.req;
                s_fwd_read    <= w.fwd;
                s_rev_read    <= w.rev;
                s_chrom_start <= w.start;
                s_bin_index   <= w.idx;
                s_valid       <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check each result word against the oldest expectation
    always @(posedge aclk) begin
        bin_read_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reads.size() == 0) begin
                $error("unexpected result word: bin_count %0d total_hits %0d",
                       m_bin_count, m_total_hits);
                errors++;
            end else begin
                e = expected_reads.pop_front();
                if (m_bin_count !== e.bin_count) begin
                    $error("bin_count mismatch: expected %0d, actual %0d",
                           e.bin_count, m_bin_count);
                    errors++;
                end
                if (m_total_hits !== e.total_hits) begin
                    $error("total_hits mismatch: expected %0d, actual %0d",
                           e.total_hits, m_total_hits);
                    errors++;
                end
            end
        end
    end

    task automatic push_word(input logic [1:0] req, input logic fwd, input logic rev,
                             input logic start, input logic [IDX_W-1:0] idx);
        hist_word_t w;
        w.req   = req;
        w.fwd   = fwd;
        w.rev   = rev;
        w.start = start;
        w.idx   = idx;
        pending_words.push_back(w);
    endtask

    task automatic push_sample(input logic fwd, input logic rev, input logic start);
        push_word(REQ_SAMPLE, fwd, rev, start, IDX_W'($urandom_range(BIN_LAST)));
    endtask

    task automatic push_read(input logic [IDX_W-1:0] idx);
        push_word(REQ_READ, 1'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 72; receiver_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 72; end
            default:       begin sender_idle_pct = 25; receiver_stall_pct = 25; end
        endcase
    endtask

    // Close a phase with a read, then wait until every word has gone through
    task automatic finish_phase();
        push_read(IDX_W'($urandom_range(7)));
        do @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_reads.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        shift_q = value;
    endtask

    function automatic int pick_density();
        case ($urandom_range(3))
            0:       return 10;
            1:       return 30;
            2:       return 50;
            default: return 80;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_bin();
        int r;
        r = $urandom_range(9);
        if (r < 6) return IDX_W'($urandom_range(31));
        if (r < 8) return IDX_W'($urandom_range(BIN_LAST));
        if (r == 8) return BIN_LAST[IDX_W-1:0];
        return IDX_W'($urandom_range(255, 32));
    endfunction

    // Queue chromosome runs with random read content, reads, clears and noise
    task automatic queue_chromosomes(input int n_words, input int seg_lo, input int seg_hi);
        int made;
        int seg_left;
        int fwd_pct;
        int rev_pct;
        int r;
        made     = 0;
        seg_left = 0;
        fwd_pct  = 50;
        rev_pct  = 50;
        while (made < n_words) begin
            r = $urandom_range(999);
            if (seg_left == 0) begin
                seg_left = $urandom_range(seg_hi, seg_lo);
                fwd_pct  = pick_density();
                rev_pct  = pick_density();
                push_sample(1'($urandom), 1'($urandom), 1'b1);
                seg_left--;
                made++;
            end else if (r < 3) begin
                push_word(REQ_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom),
                          IDX_W'($urandom_range(BIN_LAST)));
                made++;
            end else if (r < 20) begin
                // ignored word, not counted
                push_word(REQ_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom),
                          IDX_W'($urandom_range(BIN_LAST)));
            end else if (r < 120) begin
                push_read(pick_bin());
                made++;
            end else if (r < 135) begin
                // broken run: restart the chromosome early
                push_sample(1'($urandom), 1'($urandom), 1'b1);
                made++;
            end else begin
                push_sample($urandom_range(99) < fwd_pct, $urandom_range(99) < rev_pct, 1'b0);
                seg_left--;
                made++;
            end
        end
    endtask

    initial begin
        int shifts [8];
        int s;
        for (int i = 0; i < NUM_BINS_DEF; i++) gap_hist[i] = '0;
        set_idling(IDLE_NONE);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at zero shift
        write_shift(16'd0);
        push_read(12'd0);
        push_word(REQ_SAMPLE, 1'b1, 1'b1, 1'b1, 12'hFFF);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b0, 1'b1, 1'b0);
        push_sample(1'b1, 1'b0, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_read(12'd0);
        push_read(12'd1);
        push_read(12'd3);
        push_read(12'hFFF);
        push_read(12'd2);
        push_word(REQ_UNUSED, 1'b1, 1'b1, 1'b1, 12'hFFF);
        push_word(REQ_SAMPLE, 1'b1, 1'b1, 1'b1, 12'd0);
        push_read(12'd0);
        push_word(REQ_CLEAR, 1'b1, 1'b1, 1'b1, 12'hFFF);
        push_read(12'd0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_read(12'd1);
        finish_phase();

        // Shift of one: first position not eligible, next one pairs with it
        write_shift(16'd1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b1, 1'b0);
        push_read(12'd0);
        finish_phase();

        // Long gap, then a chromosome start resets the gap
        write_shift(16'd0);
        set_idling(IDLE_SENDER);
        push_sample(1'b0, 1'b0, 1'b1);
        repeat (200) push_sample(1'($urandom), 1'b0, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_read(12'd201);
        repeat (50) push_sample(1'($urandom), 1'b0, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);
        push_read(12'd0);
        finish_phase();

        // Random phases over several shifts and idling patterns
        shifts = '{1, 2, 7, 0, 33, 255, 0, 64};
        shifts[6] = $urandom_range(60, 3);
        for (int p = 0; p < 8; p++) begin
            s = shifts[p];
            write_shift(SHIFT_W'(s));
            set_idling(idle_mode_t'(p % 4));
            queue_chromosomes(80, s + 10, 3 * s + 200);
            finish_phase();
        end

        // Longest shift: no position of a short chromosome is eligible
        write_shift(16'hFFFF);
        set_idling(IDLE_NONE);
        push_sample(1'b1, 1'b1, 1'b1);
        repeat (60) push_sample(1'($urandom), 1'($urandom), 1'b0);
        push_read(12'd0);
        push_read(12'd1);
        finish_phase();

        // Small shift again under mixed idling
        write_shift(16'd3);
        set_idling(IDLE_BOTH);
        queue_chromosomes(60, 13, 200);
        finish_phase();

        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_reads.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Give up after a generous fixed time
    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/phgh_pkg.sv
rtl/phgh_front.sv
rtl/phgh_queue.sv
rtl/phgh_back.sv
rtl/paired_hit_gap_histogram.sv
rtl/phgh_checker.sv
verif/tb_top.sv
